FILE: sv/htc_pkg.sv
`timescale 1ns / 1ps
// Package for the hoist travel controller: field widths, mode, button,
// event kind and register index codes. No dependencies.
package htc_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned ButtonW = 3;
  localparam int unsigned SampleW = 10;
  localparam int unsigned DriveW  = 2;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned PosW    = 16;
  localparam int unsigned MsW     = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  typedef logic [KindW-1:0]          kind_t;
  typedef logic [ButtonW-1:0]        button_t;
  typedef logic [SampleW-1:0]        sample_t;
  typedef logic [DriveW-1:0]         drive_t;
  typedef logic [ModeW-1:0]          mode_t;
  typedef logic signed [PosW-1:0]    pos_t;
  typedef logic [MsW-1:0]            ms_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;
  typedef logic [CfgDatW-1:0]        cfg_dat_t;

  // Event kinds.
  localparam kind_t K_TICK    = 3'd0;
  localparam kind_t K_EDGE    = 3'd1;
  localparam kind_t K_BUTTON  = 3'd2;
  localparam kind_t K_CURRENT = 3'd3;
  localparam kind_t K_SUPPLY  = 3'd4;

  // Buttons.
  localparam button_t B_POWER       = 3'd0;
  localparam button_t B_RAISE       = 3'd1;
  localparam button_t B_LOWER       = 3'd2;
  localparam button_t B_RESET       = 3'd3;
  localparam button_t B_TEACH_RAISE = 3'd4;
  localparam button_t B_TEACH_LOWER = 3'd5;
  localparam button_t B_NONE        = 3'd7;

  // Modes.
  localparam mode_t M_FACTORY      = 3'd0;
  localparam mode_t M_RESET_DONE   = 3'd1;
  localparam mode_t M_LOWER_TAUGHT = 3'd2;
  localparam mode_t M_RISING       = 3'd3;
  localparam mode_t M_AT_TOP       = 3'd4;
  localparam mode_t M_LOWERING     = 3'd5;
  localparam mode_t M_AT_BOTTOM    = 3'd6;
  localparam mode_t M_OVERLOAD     = 3'd7;

  // Motor drive.
  localparam drive_t D_STOP  = 2'd0;
  localparam drive_t D_RAISE = 2'd1;
  localparam drive_t D_LOWER = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t R_OVERCURRENT = 3'd0;
  localparam cfg_idx_t R_DEBOUNCE    = 3'd1;
  localparam cfg_idx_t R_PERIOD      = 3'd2;
  localparam cfg_idx_t R_FACTORY     = 3'd3;
  localparam cfg_idx_t R_SUPPLY      = 3'd4;
  localparam cfg_idx_t R_SAVED_POS   = 3'd5;
  localparam cfg_idx_t R_SAVED_LIMIT = 3'd6;
  localparam cfg_idx_t R_SAVED_MODE  = 3'd7;

  // Register reset values.
  localparam logic [9:0]  OVERCURRENT_RST = 10'd682;
  localparam logic [9:0]  DEBOUNCE_RST    = 10'd20;
  localparam logic [13:0] PERIOD_RST      = 14'd200;
  localparam logic [15:0] FACTORY_RST     = 16'd5000;
  localparam logic [9:0]  SUPPLY_RST      = 10'd1000;

  localparam pos_t POS_MAX = 16'sh7FFF;
  localparam pos_t POS_MIN = -16'sh8000;

endpackage

FILE: sv/htc_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the hoist travel controller:
// event input, status result and register write. Depends on htc_pkg.
interface htc_in_if import htc_pkg::*; ();
  logic    valid;
  logic    ready;
  kind_t   kind;
  button_t button;
  logic    level;
  sample_t sample;
  modport source (output valid, kind, button, level, sample, input ready);
  modport sink   (input valid, kind, button, level, sample, output ready);
endinterface

interface htc_out_if import htc_pkg::*; ();
  logic   valid;
  logic   ready;
  drive_t motor_drive;
  logic   powered;
  mode_t  mode;
  pos_t   position;
  pos_t   travel_limit;
  logic   teaching;
  logic   persist;
  modport source (output valid, motor_drive, powered, mode, position, travel_limit,
                  teaching, persist, input ready);
  modport sink   (input valid, motor_drive, powered, mode, position, travel_limit,
                  teaching, persist, output ready);
endinterface

interface htc_cfg_if import htc_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_dat_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/hoist_travel_controller.sv
`timescale 1ns / 1ps
// Hoist travel controller top level. Depends on htc_pkg and the channel
// interfaces in htc_channels.sv.

// Each input event (millisecond tick, encoder edge, button change, current
// or supply sample) is handled in the cycle it is transferred and gives one
// status result in the next cycle; the state registers themselves form the
// result register. One event per cycle is sustained as long as results are
// taken; while a result waits, a new event is still transferred if the
// result is taken in the same cycle. Register writes are always accepted and
// the saved position, limit and mode writes load the live state at once.
module hoist_travel_controller import htc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  htc_in_if.sink       in_ch,
  htc_out_if.source    out_ch,
  htc_cfg_if.sink      cfg_ch
);

  // Configuration registers.
  logic [9:0]  overcurrent_r;
  logic [9:0]  debounce_r;
  logic [13:0] period_r;
  logic [15:0] factory_hold_r;
  logic [9:0]  supply_level_r;

  // Controller state.
  logic    on_r, on_nxt;
  logic    teach_r, teach_nxt;
  mode_t   mode_r, mode_nxt;
  pos_t    pos_r, pos_nxt;
  pos_t    limit_r, limit_nxt;
  drive_t  drive_r, drive_nxt;
  ms_t     ms_now_r, ms_now_nxt;
  ms_t     last_edge_r, last_edge_nxt;
  ms_t     last_check_r, last_check_nxt;
  button_t held_r, held_nxt;
  ms_t     press_r, press_nxt;
  logic    persist_r, persist_nxt;
  logic    out_valid_r;

  logic in_fire;
  logic cfg_fire;
  ms_t  edge_gap;
  ms_t  check_gap;
  ms_t  held_time;
  pos_t pos_inc;
  pos_t pos_dec;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;

  assign edge_gap  = ms_now_r - last_edge_r;
  assign check_gap = ms_now_r - last_check_r;
  assign held_time = ms_now_r - press_r;
  assign pos_inc   = (pos_r == POS_MAX) ? pos_r : pos_r + 16'sd1;
  assign pos_dec   = (pos_r == POS_MIN) ? pos_r : pos_r - 16'sd1;

  always_comb begin
    on_nxt         = on_r;
    teach_nxt      = teach_r;
    mode_nxt       = mode_r;
    pos_nxt        = pos_r;
    limit_nxt      = limit_r;
    drive_nxt      = drive_r;
    ms_now_nxt     = ms_now_r;
    last_edge_nxt  = last_edge_r;
    last_check_nxt = last_check_r;
    held_nxt       = held_r;
    press_nxt      = press_r;
    persist_nxt    = 1'b0;

    unique case (in_ch.kind)
      K_TICK: begin
        ms_now_nxt = ms_now_r + 32'd1;
      end
      K_EDGE: begin
        if (edge_gap > {22'd0, debounce_r}) begin
          last_edge_nxt = ms_now_r;
          if (teach_r) begin
            if (mode_r == M_RISING) pos_nxt = pos_inc;
          end else if (mode_r == M_LOWERING || mode_r == M_AT_BOTTOM) begin
            pos_nxt = pos_dec;
            if (pos_dec <= 16'sd0) begin
              drive_nxt = D_STOP;
              mode_nxt  = M_AT_BOTTOM;
            end
          end else if (mode_r == M_RISING || mode_r == M_AT_TOP) begin
            pos_nxt = pos_inc;
            if (pos_inc >= limit_r) begin
              drive_nxt = D_STOP;
              mode_nxt  = M_AT_TOP;
            end
          end
        end
      end
      K_BUTTON: begin
        if (in_ch.button <= B_TEACH_LOWER) begin
          if (in_ch.level) begin
            if (held_r == B_NONE) begin
              held_nxt  = in_ch.button;
              press_nxt = ms_now_r;
            end
          end else if (held_r == in_ch.button) begin
            // Release of the held button: this is where buttons act.
            held_nxt = B_NONE;
            if (!on_r) begin
              if (in_ch.button == B_POWER) begin
                on_nxt    = 1'b1;
                drive_nxt = D_STOP;
              end
            end else if (in_ch.button == B_POWER) begin
              on_nxt    = 1'b0;
              drive_nxt = D_STOP;
            end else if (in_ch.button == B_RESET) begin
              if (mode_r == M_RESET_DONE) begin
                if (held_time >= {16'd0, factory_hold_r}) begin
                  mode_nxt    = M_FACTORY;
                  persist_nxt = 1'b1;
                end
              end else begin
                drive_nxt   = D_STOP;
                pos_nxt     = '0;
                limit_nxt   = '0;
                mode_nxt    = M_RESET_DONE;
                persist_nxt = 1'b1;
              end
            end else begin
              unique case (mode_r)
                M_RESET_DONE: begin
                  if (in_ch.button == B_TEACH_LOWER) begin
                    teach_nxt   = 1'b1;
                    pos_nxt     = '0;
                    limit_nxt   = '0;
                    mode_nxt    = M_LOWERING;
                    drive_nxt   = D_LOWER;
                    persist_nxt = 1'b1;
                  end
                end
                M_LOWER_TAUGHT: begin
                  if (in_ch.button == B_TEACH_RAISE) begin
                    mode_nxt    = M_RISING;
                    teach_nxt   = 1'b1;
                    drive_nxt   = D_RAISE;
                    persist_nxt = 1'b1;
                  end
                end
                M_RISING: begin
                  if (in_ch.button == B_TEACH_RAISE && teach_r) begin
                    drive_nxt   = D_STOP;
                    limit_nxt   = pos_r;
                    mode_nxt    = M_AT_TOP;
                    teach_nxt   = 1'b0;
                    persist_nxt = 1'b1;
                  end
                end
                M_AT_TOP: begin
                  if (in_ch.button == B_LOWER) begin
                    mode_nxt  = M_LOWERING;
                    drive_nxt = D_LOWER;
                  end
                end
                M_LOWERING: begin
                  if (in_ch.button == B_TEACH_LOWER && teach_r) begin
                    drive_nxt   = D_STOP;
                    limit_nxt   = '0;
                    mode_nxt    = M_LOWER_TAUGHT;
                    teach_nxt   = 1'b0;
                    persist_nxt = 1'b1;
                  end
                end
                M_AT_BOTTOM: begin
                  if (in_ch.button == B_RAISE) begin
                    mode_nxt  = M_RISING;
                    drive_nxt = D_RAISE;
                  end
                end
                M_OVERLOAD: begin
                  if (in_ch.button == B_LOWER) begin
                    drive_nxt   = D_LOWER;
                    mode_nxt    = M_AT_BOTTOM;
                    persist_nxt = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      K_CURRENT: begin
        if (on_r && mode_r == M_LOWERING && check_gap >= {18'd0, period_r}) begin
          if (in_ch.sample > overcurrent_r) begin
            drive_nxt   = D_STOP;
            mode_nxt    = M_OVERLOAD;
            persist_nxt = 1'b1;
          end
          last_check_nxt = ms_now_r;
        end
      end
      K_SUPPLY: begin
        if (in_ch.sample > supply_level_r) begin
          mode_nxt    = M_AT_TOP;
          persist_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      overcurrent_r  <= OVERCURRENT_RST;
      debounce_r     <= DEBOUNCE_RST;
      period_r       <= PERIOD_RST;
      factory_hold_r <= FACTORY_RST;
      supply_level_r <= SUPPLY_RST;
      on_r           <= 1'b0;
      teach_r        <= 1'b0;
      mode_r         <= M_FACTORY;
      pos_r          <= '0;
      limit_r        <= '0;
      drive_r        <= D_STOP;
      ms_now_r       <= '0;
      last_edge_r    <= '0;
      last_check_r   <= '0;
      held_r         <= B_NONE;
      press_r        <= '0;
      persist_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        on_r         <= on_nxt;
        teach_r      <= teach_nxt;
        mode_r       <= mode_nxt;
        pos_r        <= pos_nxt;
        limit_r      <= limit_nxt;
        drive_r      <= drive_nxt;
        ms_now_r     <= ms_now_nxt;
        last_edge_r  <= last_edge_nxt;
        last_check_r <= last_check_nxt;
        held_r       <= held_nxt;
        press_r      <= press_nxt;
        persist_r    <= persist_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // Register writes should happen only while idle; the block does not enforce this, and a write simply wins.
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          R_OVERCURRENT: overcurrent_r  <= cfg_ch.data[9:0];
          R_DEBOUNCE:    debounce_r     <= cfg_ch.data[9:0];
          R_PERIOD:      period_r       <= cfg_ch.data[13:0];
          R_FACTORY:     factory_hold_r <= cfg_ch.data;
          R_SUPPLY:      supply_level_r <= cfg_ch.data[9:0];
          R_SAVED_POS:   pos_r          <= pos_t'(cfg_ch.data);
          R_SAVED_LIMIT: limit_r        <= pos_t'(cfg_ch.data);
          R_SAVED_MODE:  mode_r         <= cfg_ch.data[2:0];
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.motor_drive  = drive_r;
  assign out_ch.powered      = on_r;
  assign out_ch.mode         = mode_r;
  assign out_ch.position     = pos_r;
  assign out_ch.travel_limit = limit_r;
  assign out_ch.teaching     = teach_r;
  assign out_ch.persist      = persist_r;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for hoist_travel_controller: random and directed events,
// a cycle-free status predictor and a field-by-field result check.
// Depends on htc_pkg and the channel interfaces in htc_channels.sv.
module tb_top;
  import htc_pkg::*;

  // Event kinds and a button code that the block is meant to ignore.
  localparam kind_t   K_SPARE_LO = 3'd5;
  localparam kind_t   K_SPARE_HI = 3'd7;
  localparam button_t B_SPARE    = 3'd6;

  typedef struct packed {
    kind_t   kind;
    button_t button;
    logic    level;
    sample_t sample;
  } hoist_event_t;

  typedef struct {
    drive_t drive;
    logic   powered;
    mode_t  mode;
    pos_t   position;
    pos_t   limit;
    logic   teaching;
    logic   persist;
  } hoist_status_t;

  logic clk = 1'b0;
  logic rst_n;

  htc_in_if  in_if ();
  htc_out_if out_if ();
  htc_cfg_if cfg_if ();

  hoist_travel_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Register mirror.
  logic [9:0]  rg_oc       = OVERCURRENT_RST;
  logic [9:0]  rg_debounce = DEBOUNCE_RST;
  logic [13:0] rg_period   = PERIOD_RST;
  logic [15:0] rg_fhold    = FACTORY_RST;
  logic [9:0]  rg_supply   = SUPPLY_RST;

  // Predicted controller state.
  logic    hs_on       = 1'b0;
  mode_t   hs_mode     = M_FACTORY;
  pos_t    hs_pos      = '0;
  pos_t    hs_limit    = '0;
  logic    hs_teach    = 1'b0;
  drive_t  hs_drive    = D_STOP;
  ms_t     hs_ms       = '0;
  ms_t     hs_edge_ms  = '0;
  ms_t     hs_check_ms = '0;
  button_t hs_held     = B_NONE;
  ms_t     hs_press_ms = '0;

  hoist_event_t  event_q[$];
  hoist_status_t status_q[$];
  int            pending_events = 0;
  int            mismatch_count = 0;
  int            result_count   = 0;

  // Generator view of the power flag and held button; both follow from the
  // button events alone, so they are exact at generation time.
  logic    g_on   = 1'b0;
  button_t g_held = B_NONE;
  int      gen_count;

  logic          in_taken = 1'b0;
  hoist_event_t  drv_ev;
  hoist_event_t  seen_ev;
  hoist_status_t pred_st;
  hoist_status_t want_st;
  int            burst_left = 0;
  int            gap_left   = 0;
  int            rx_style   = 0;
  int            rx_left    = 0;
  int            hold_left  = 0;
  int            long_hold_req = 0;

  int plan [6][8] = '{
    '{0,    0,    0,     0,     1023, 0,      0,      M_RESET_DONE},
    '{1023, 1000, 10000, 60000, 0,    -32768, 32767,  M_LOWERING},
    '{500,  2,    5,     4,     900,  10,     20,     M_AT_BOTTOM},
    '{300,  1,    3,     2,     1000, 32767,  -32768, M_OVERLOAD},
    '{682,  3,    10,    6,     1010, 0,      0,      M_FACTORY},
    '{800,  0,    1,     1,     700,  -5,     100,    M_RISING}
  };

  function automatic pos_t sat_pos(input int v);
    if (v > 32767) return POS_MAX;
    if (v < -32768) return POS_MIN;
    return pos_t'(v);
  endfunction

  function automatic int capped(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic step_hoist(input hoist_event_t ev, output hoist_status_t st);
    logic store;
    ms_t  held_for;
    store    = 1'b0;
    held_for = '0;
    case (ev.kind)
      K_TICK: hs_ms = hs_ms + 1;
      K_EDGE: begin
        if (ms_t'(hs_ms - hs_edge_ms) > ms_t'(rg_debounce)) begin
          hs_edge_ms = hs_ms;
          if (hs_teach) begin
            if (hs_mode == M_RISING) hs_pos = sat_pos(hs_pos + 1);
          end else if (hs_mode == M_LOWERING || hs_mode == M_AT_BOTTOM) begin
            hs_pos = sat_pos(hs_pos - 1);
            if (hs_pos <= 0) begin
              hs_drive = D_STOP;
              hs_mode  = M_AT_BOTTOM;
            end
          end else if (hs_mode == M_RISING || hs_mode == M_AT_TOP) begin
            hs_pos = sat_pos(hs_pos + 1);
            if (hs_pos >= hs_limit) begin
              hs_drive = D_STOP;
              hs_mode  = M_AT_TOP;
            end
          end
        end
      end
      K_BUTTON: begin
        if (ev.button <= B_TEACH_LOWER) begin
          if (ev.level) begin
            if (hs_held == B_NONE) begin
              hs_held     = ev.button;
              hs_press_ms = hs_ms;
            end
          end else if (hs_held == ev.button) begin
            hs_held  = B_NONE;
            held_for = hs_ms - hs_press_ms;
            if (!hs_on) begin
              if (ev.button == B_POWER) begin
                hs_on    = 1'b1;
                hs_drive = D_STOP;
              end
            end else if (ev.button == B_POWER) begin
              hs_on    = 1'b0;
              hs_drive = D_STOP;
            end else if (ev.button == B_RESET) begin
              if (hs_mode == M_RESET_DONE) begin
                if (held_for >= ms_t'(rg_fhold)) begin
                  hs_mode = M_FACTORY;
                  store   = 1'b1;
                end
              end else begin
                hs_drive = D_STOP;
                hs_pos   = '0;
                hs_limit = '0;
                hs_mode  = M_RESET_DONE;
                store    = 1'b1;
              end
            end else begin
              case (hs_mode)
                M_RESET_DONE: begin
                  if (ev.button == B_TEACH_LOWER) begin
                    hs_teach = 1'b1;
                    hs_pos   = '0;
                    hs_limit = '0;
                    hs_mode  = M_LOWERING;
                    hs_drive = D_LOWER;
                    store    = 1'b1;
                  end
                end
                M_LOWER_TAUGHT: begin
                  if (ev.button == B_TEACH_RAISE) begin
                    hs_mode  = M_RISING;
                    hs_teach = 1'b1;
                    hs_drive = D_RAISE;
                    store    = 1'b1;
                  end
                end
                M_RISING: begin
                  if (ev.button == B_TEACH_RAISE && hs_teach) begin
                    hs_drive = D_STOP;
                    hs_limit = hs_pos;
                    hs_mode  = M_AT_TOP;
                    hs_teach = 1'b0;
                    store    = 1'b1;
                  end
                end
                M_AT_TOP: begin
                  if (ev.button == B_LOWER) begin
                    hs_mode  = M_LOWERING;
                    hs_drive = D_LOWER;
                  end
                end
                M_LOWERING: begin
                  if (ev.button == B_TEACH_LOWER && hs_teach) begin
                    hs_drive = D_STOP;
                    hs_limit = '0;
                    hs_mode  = M_LOWER_TAUGHT;
                    hs_teach = 1'b0;
                    store    = 1'b1;
                  end
                end
                M_AT_BOTTOM: begin
                  if (ev.button == B_RAISE) begin
                    hs_mode  = M_RISING;
                    hs_drive = D_RAISE;
                  end
                end
                M_OVERLOAD: begin
                  if (ev.button == B_LOWER) begin
                    hs_drive = D_LOWER;
                    hs_mode  = M_AT_BOTTOM;
                    store    = 1'b1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      K_CURRENT: begin
        if (hs_on && hs_mode == M_LOWERING &&
            ms_t'(hs_ms - hs_check_ms) >= ms_t'(rg_period)) begin
          if (ev.sample > rg_oc) begin
            hs_drive = D_STOP;
            hs_mode  = M_OVERLOAD;
            store    = 1'b1;
          end
          hs_check_ms = hs_ms;
        end
      end
      K_SUPPLY: begin
        if (ev.sample > rg_supply) begin
          hs_mode = M_AT_TOP;
          store   = 1'b1;
        end
      end
      default: ;
    endcase
    st.drive    = hs_drive;
    st.powered  = hs_on;
    st.mode     = hs_mode;
    st.position = hs_pos;
    st.limit    = hs_limit;
    st.teaching = hs_teach;
    st.persist  = store;
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("MISMATCH result %0d %s: got %0d, want %0d", result_count, what, got, want);
  endtask

  // Result check, then prediction for the event transferred at this edge.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        result_count++;
        if (status_q.size() == 0) begin
          report_mismatch("result with none outstanding", 0, 0);
        end else begin
          want_st = status_q.pop_front();
          if (out_if.motor_drive !== want_st.drive)
            report_mismatch("motor_drive", out_if.motor_drive, want_st.drive);
          if (out_if.powered !== want_st.powered)
            report_mismatch("powered", out_if.powered, want_st.powered);
          if (out_if.mode !== want_st.mode)
            report_mismatch("mode", out_if.mode, want_st.mode);
          if (out_if.position !== want_st.position)
            report_mismatch("position", out_if.position, want_st.position);
          if (out_if.travel_limit !== want_st.limit)
            report_mismatch("travel_limit", out_if.travel_limit, want_st.limit);
          if (out_if.teaching !== want_st.teaching)
            report_mismatch("teaching", out_if.teaching, want_st.teaching);
          if (out_if.persist !== want_st.persist)
            report_mismatch("persist", out_if.persist, want_st.persist);
        end
      end
      if (in_if.valid && in_if.ready) begin
        in_taken       = 1'b1;
        seen_ev.kind   = in_if.kind;
        seen_ev.button = in_if.button;
        seen_ev.level  = in_if.level;
        seen_ev.sample = in_if.sample;
        step_hoist(seen_ev, pred_st);
        status_q.push_back(pred_st);
        pending_events--;
      end
    end
  end

  // Event driver: bursts of random length with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left != 0 || event_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_if.valid <= 1'b0;
      end else begin
        drv_ev = event_q.pop_front();
        in_if.valid  <= 1'b1;
        in_if.kind   <= drv_ev.kind;
        in_if.button <= drv_ev.button;
        in_if.level  <= drv_ev.level;
        in_if.sample <= drv_ev.sample;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
  end

  // Result receiver: a changing stall pattern, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (long_hold_req != 0) begin
      long_hold_req = 0;
      hold_left     = 400;
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_left  = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_style)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        2:       out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_event(input kind_t k, input button_t b, input logic lv,
                            input sample_t s);
    hoist_event_t ev;
    ev.kind   = k;
    ev.button = b;
    ev.level  = lv;
    ev.sample = s;
    if (k == K_BUTTON && b <= B_TEACH_LOWER) begin
      if (lv) begin
        if (g_held == B_NONE) g_held = b;
      end else if (g_held == b) begin
        g_held = B_NONE;
        if (b == B_POWER) g_on = !g_on;
      end
    end
    event_q.push_back(ev);
    pending_events++;
    gen_count++;
  endtask

  // Non-button events carry random values in the fields the block ignores.
  task automatic push_sample(input kind_t k, input int s);
    push_event(k, button_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), sample_t'(s));
  endtask

  task automatic push_kind(input kind_t k);
    push_sample(k, $urandom_range(0, 1023));
  endtask

  task automatic tick_n(input int n);
    repeat (n) push_kind(K_TICK);
  endtask

  task automatic tap(input button_t b, input int hold);
    push_event(K_BUTTON, b, 1'b1, sample_t'($urandom_range(0, 1023)));
    tick_n(hold);
    push_event(K_BUTTON, b, 1'b0, sample_t'($urandom_range(0, 1023)));
  endtask

  // Encoder edges, mostly spaced just past a short debounce window; a long window is not waited out.
  task automatic stroke(input int n);
    int gap;
    repeat (n) begin
      gap = capped(int'(rg_debounce) + 1, 8);
      if ($urandom_range(0, 9) < 3) gap = $urandom_range(0, gap);
      tick_n(gap);
      push_kind(K_EDGE);
    end
  endtask

  task automatic current_probe();
    int lvl;
    lvl = int'(rg_oc);
    case ($urandom_range(0, 3))
      0:       push_sample(K_CURRENT, lvl);
      1:       push_sample(K_CURRENT, capped(lvl + 1, 1023));
      default: push_kind(K_CURRENT);
    endcase
  endtask

  task automatic ensure_on();
    if (g_held != B_NONE)
      push_event(K_BUTTON, g_held, 1'b0, sample_t'($urandom_range(0, 1023)));
    if (!g_on) tap(B_POWER, $urandom_range(0, 2));
  endtask

  // A whole teach run followed by normal travel in both directions.
  task automatic travel_run();
    int h;
    ensure_on();
    tap(B_RESET, $urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) begin
      if (rg_fhold <= 12) h = int'(rg_fhold) + int'($urandom_range(0, 2)) - 1;
      else h = $urandom_range(0, 12);
      if (h < 0) h = 0;
      tap(B_RESET, h);
    end
    tap(B_TEACH_LOWER, $urandom_range(0, 1));
    stroke($urandom_range(0, 3));
    current_probe();
    tap(B_TEACH_LOWER, $urandom_range(0, 1));
    tap(B_TEACH_RAISE, $urandom_range(0, 1));
    stroke($urandom_range(2, 8));
    tap(B_TEACH_RAISE, $urandom_range(0, 1));
    tap(B_LOWER, $urandom_range(0, 1));
    repeat ($urandom_range(1, 4)) begin
      stroke($urandom_range(1, 3));
      current_probe();
    end
    tap(B_RAISE, $urandom_range(0, 1));
    stroke($urandom_range(1, 6));
  endtask

  task automatic gen_random(input int n);
    int      r;
    button_t a;
    gen_count = 0;
    while (gen_count < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        travel_run();
      end else if (r < 50) begin
        tick_n($urandom_range(1, 4));
      end else if (r < 62) begin
        stroke($urandom_range(1, 3));
      end else if (r < 72) begin
        current_probe();
      end else if (r < 78) begin
        if ($urandom_range(0, 4) == 0) push_kind(K_SUPPLY);
        else push_sample(K_SUPPLY, $urandom_range(0, int'(rg_supply)));
      end else if (r < 88) begin
        tap(button_t'($urandom_range(0, 7)), $urandom_range(0, 3));
      end else if (r < 94) begin
        // A second button pressed and released while the first is held.
        a = button_t'($urandom_range(0, 5));
        push_event(K_BUTTON, a, 1'b1, sample_t'($urandom_range(0, 1023)));
        tap(button_t'($urandom_range(0, 7)), $urandom_range(0, 1));
        push_event(K_BUTTON, a, 1'b0, sample_t'($urandom_range(0, 1023)));
      end else if (r < 97) begin
        push_event(K_BUTTON, button_t'($urandom_range(0, 7)), 1'b0,
                   sample_t'($urandom_range(0, 1023)));
      end else begin
        push_kind(kind_t'($urandom_range(K_SPARE_LO, K_SPARE_HI)));
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_dat_t d;
    d = cfg_dat_t'(value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      R_OVERCURRENT: rg_oc       = d[9:0];
      R_DEBOUNCE:    rg_debounce = d[9:0];
      R_PERIOD:      rg_period   = d[13:0];
      R_FACTORY:     rg_fhold    = d;
      R_SUPPLY:      rg_supply   = d[9:0];
      R_SAVED_POS:   hs_pos      = pos_t'(d);
      R_SAVED_LIMIT: hs_limit    = pos_t'(d);
      R_SAVED_MODE:  hs_mode     = d[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every event has been transferred and every result checked.
  task automatic settle();
    @(negedge clk);
    while (pending_events != 0 || status_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin : stimulus
    in_if.valid  = 1'b0;
    in_if.kind   = K_TICK;
    in_if.button = B_POWER;
    in_if.level  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = R_OVERCURRENT;
    cfg_if.data  = '0;
    rst_n        = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed events at the reset settings.
    push_kind(K_TICK);
    push_event(K_SPARE_LO, B_NONE, 1'b1, 10'h3FF);
    push_event(K_SPARE_HI, B_POWER, 1'b0, 10'h000);
    push_event(K_BUTTON, B_SPARE, 1'b1, 10'h000);
    push_event(K_BUTTON, B_SPARE, 1'b0, 10'h3FF);
    push_event(K_BUTTON, B_POWER, 1'b1, 10'h155);
    push_event(K_BUTTON, B_RAISE, 1'b1, 10'h2AA);   // ignored, power is held
    push_event(K_BUTTON, B_RAISE, 1'b0, 10'h000);   // release of a button not held
    push_event(K_BUTTON, B_POWER, 1'b0, 10'h000);   // switches on
    push_sample(K_CURRENT, 1023);                   // not lowering, not evaluated
    push_sample(K_SUPPLY, 1000);                    // at the level, no save
    push_sample(K_SUPPLY, 1001);                    // spike saves state
    tap(B_RESET, 0);
    tap(B_RESET, 1);                                // short hold in reset_done
    tap(B_TEACH_LOWER, 0);
    push_sample(K_CURRENT, 1023);                   // check period not yet elapsed
    push_kind(K_EDGE);                              // inside the debounce window
    tap(B_TEACH_LOWER, 0);
    tap(B_TEACH_RAISE, 0);
    tap(B_LOWER, 0);
    tap(B_TEACH_RAISE, 0);
    tap(B_POWER, 0);
    tap(B_RAISE, 0);                                // powered off, ignored

    // Position saturation at both bounds, then an overcurrent trip.
    settle();
    write_reg(R_DEBOUNCE, 0);
    write_reg(R_PERIOD, 0);
    write_reg(R_SAVED_LIMIT, 32767);
    write_reg(R_SAVED_POS, 32766);
    write_reg(R_SAVED_MODE, M_AT_TOP);
    tap(B_POWER, 0);
    repeat (2) begin
      push_kind(K_TICK);
      push_kind(K_EDGE);
    end
    settle();
    write_reg(R_SAVED_POS, -32767);
    write_reg(R_SAVED_MODE, M_LOWERING);
    repeat (2) begin
      push_kind(K_TICK);
      push_kind(K_EDGE);
    end
    settle();
    write_reg(R_SAVED_MODE, M_LOWERING);
    push_sample(K_CURRENT, 683);
    tap(B_LOWER, 0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      for (int r = 0; r < 8; r++) write_reg(cfg_idx_t'(r), plan[ph][r]);
      if (ph == 2) begin
        gen_random(320);
        long_hold_req = 1;
      end else if (ph == 3) begin
        gen_random(160);
        settle();
        gen_random(160);
      end else begin
        gen_random(320);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
